// ===== rtl/core/aes_pkg.sv =====
// Types, constants and round functions shared by the AES-128 encryption core.
`default_nettype none
package aes_pkg;

  typedef logic [0:15][7:0] aes_state_t;
  typedef logic [63:0]      half_t;
  typedef logic [7:0]       cfg_index_t;

  localparam cfg_index_t REG_KEY_HI = 8'd0;
  localparam cfg_index_t REG_KEY_LO = 8'd1;

  typedef struct packed {
    aes_state_t state;
    aes_state_t key;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] GF_POLY = 8'h1b;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input int unsigned n);
    logic [7:0] r;
    r = 8'h01;
    for (int unsigned i = 0; i < n; i++) begin
      r = xtime(r);
    end
    return r;
  endfunction

  function automatic aes_state_t sub_shift(input aes_state_t s);
    aes_state_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4 * c] = SBOX[s[r + 4 * ((c + r) % 4)]];
      end
    end
    return t;
  endfunction

  function automatic aes_state_t mix_columns(input aes_state_t s);
    aes_state_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[4 * c];
      a1 = s[4 * c + 1];
      a2 = s[4 * c + 2];
      a3 = s[4 * c + 3];
      t[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

  function automatic aes_state_t next_round_key(input aes_state_t rk, input logic [7:0] rc);
    aes_state_t k;
    k = rk;
    k[0] = k[0] ^ SBOX[rk[13]] ^ rc;
    k[1] = k[1] ^ SBOX[rk[14]];
    k[2] = k[2] ^ SBOX[rk[15]];
    k[3] = k[3] ^ SBOX[rk[12]];
    for (int i = 4; i < 16; i++) begin
      k[i] = k[i] ^ k[i - 4];
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/aes_block_if.sv =====
// Plaintext block channel: valid/ready handshake with two 64-bit halves.
`default_nettype none
interface aes_block_if;
  logic                valid;
  logic                ready;
  aes_pkg::half_t      block_hi;
  aes_pkg::half_t      block_lo;

  modport source (output valid, output block_hi, output block_lo, input ready);
  modport sink   (input valid, input block_hi, input block_lo, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/aes_cipher_if.sv =====
// Ciphertext block channel: valid/ready handshake with two 64-bit halves.
`default_nettype none
interface aes_cipher_if;
  logic                valid;
  logic                ready;
  aes_pkg::half_t      cipher_hi;
  aes_pkg::half_t      cipher_lo;

  modport source (output valid, output cipher_hi, output cipher_lo, input ready);
  modport sink   (input valid, input cipher_hi, input cipher_lo, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/aes_cfg_if.sv =====
// Configuration write channel: valid/ready handshake with register index and data.
`default_nettype none
interface aes_cfg_if;
  logic                  valid;
  logic                  ready;
  aes_pkg::cfg_index_t   index;
  aes_pkg::half_t        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/aes_key_add.sv =====
// Entry cell: initial key addition, hands block and key to the first round.
`default_nettype none
module aes_key_add (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire aes_pkg::aes_state_t up_block,
  input  wire aes_pkg::aes_state_t key,
  output logic                   down_valid,
  input  wire logic              down_ready,
  output aes_pkg::stage_t        down_data
);
  import aes_pkg::*;

  logic   valid;
  stage_t data;

  assign up_ready   = !valid || down_ready;
  assign down_valid = valid;
  assign down_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data.state <= up_block ^ key;
      data.key   <= key;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/aes_round.sv =====
// Round cell: key expansion, SubBytes, ShiftRows, MixColumns unless LAST, AddRoundKey.
`default_nettype none
module aes_round #(
  parameter logic [7:0] RC   = 8'h01,
  parameter bit         LAST = 1'b0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire aes_pkg::stage_t up_data,
  output logic                 down_valid,
  input  wire logic            down_ready,
  output aes_pkg::stage_t      down_data
);
  import aes_pkg::*;

  logic       valid;
  stage_t     data;
  aes_state_t round_key;
  aes_state_t shifted;
  aes_state_t mixed;

  assign up_ready   = !valid || down_ready;
  assign down_valid = valid;
  assign down_data  = data;

  always_comb begin
    round_key = next_round_key(up_data.key, RC);
    shifted   = sub_shift(up_data.state);
    mixed     = LAST ? shifted : mix_columns(shifted);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data.state <= mixed ^ round_key;
      data.key   <= round_key;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/aes128_block_encrypt.sv =====
// AES-128 encryption core: chain of one key-add cell and ROUNDS round cells.
//
//   channel  modport  payload                 role
//   cfg      sink     index, data (64)        key register writes
//   plain    sink     block_hi, block_lo      plaintext transactions in
//   cipher   source   cipher_hi, cipher_lo    ciphertext transactions out
//
// One block per cycle sustained while the output is taken; one round per cell.
// Each round cell expands its own round key from the one handed down with the block.
// A cell takes new data when it is empty or its neighbour takes its contents,
// so bubbles close up behind a stalled output.
// Synchronous reset empties the chain and clears the key to zero.
`default_nettype none
module aes128_block_encrypt #(
  parameter int unsigned ROUNDS = 10
) (
  input  wire logic clk,
  input  wire logic rst,
  aes_cfg_if.sink    cfg,
  aes_block_if.sink  plain,
  aes_cipher_if.source cipher
);
  import aes_pkg::*;

  half_t      key_hi;
  half_t      key_lo;
  aes_state_t key;
  aes_state_t block_in;

  logic       valid [ROUNDS + 1];
  logic       ready [ROUNDS + 1];
  stage_t     data  [ROUNDS + 1];

  assign cfg.ready = 1'b1;
  assign key       = {key_hi, key_lo};
  assign block_in  = {plain.block_hi, plain.block_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi <= '0;
      key_lo <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_KEY_HI: key_hi <= cfg.data;
        REG_KEY_LO: key_lo <= cfg.data;
        default: ;
      endcase
    end
  end

  aes_key_add u_key_add (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (plain.valid),
    .up_ready   (plain.ready),
    .up_block   (block_in),
    .key        (key),
    .down_valid (valid[0]),
    .down_ready (ready[0]),
    .down_data  (data[0])
  );

  for (genvar i = 1; i <= ROUNDS; i++) begin : g_round
    aes_round #(
      .RC   (rcon(i - 1)),
      .LAST (i == ROUNDS)
    ) u_round (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (valid[i - 1]),
      .up_ready   (ready[i - 1]),
      .up_data    (data[i - 1]),
      .down_valid (valid[i]),
      .down_ready (ready[i]),
      .down_data  (data[i])
    );
  end

  assign ready[ROUNDS]    = cipher.ready;
  assign cipher.valid     = valid[ROUNDS];
  assign cipher.cipher_hi = data[ROUNDS].state[0:7];
  assign cipher.cipher_lo = data[ROUNDS].state[8:15];

  a_reset_empties: assert property (@(posedge clk) $past(rst) |-> !cipher.valid)
    else $error("output valid right after reset");

  a_flow_through: assert property (@(posedge clk) disable iff (rst)
    cipher.ready |-> plain.ready)
    else $error("input stalled while output is being taken");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (valid[0] && cipher.ready) |=> (valid[1] || $past(ready[0]) == 1'b0))
    else $error("first round cell dropped a block");
endmodule
`default_nettype wire

// ===== test/aes128_block_encrypt_tb.sv =====
// Testbench for the AES-128 block encryption core: known-answer table, then random keys and blocks.
`timescale 1ns / 100ps
module aes128_block_encrypt_tb;
  import aes_pkg::*;

  localparam int unsigned ROUNDS        = 10;
  localparam int          RANDOM_BLOCKS = 700;
  localparam int          LIMIT_NS      = 2_000_000;
  localparam logic [7:0]  GF_REDUCE     = 8'h1b;
  localparam logic [7:0]  AFFINE_C      = 8'h63;
  localparam cfg_index_t  REG_FIRST_UNUSED = REG_KEY_LO + 8'd1;
  localparam cfg_index_t  REG_LAST_UNUSED  = '1;

  typedef enum logic { ROW_KEY, ROW_BLOCK } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    cfg_index_t index;
    half_t      hi;
    half_t      lo;
    bit         fixed;
    half_t      want_hi;
    half_t      want_lo;
  } stim_row_t;

  typedef struct packed {
    bit           fixed;
    logic [127:0] value;
  } pin_t;

  localparam int DIRECTED_ROWS = 23;

  stim_row_t directed [DIRECTED_ROWS] = '{
    '{ROW_BLOCK, REG_KEY_HI, 64'h0, 64'h0,
      1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
    '{ROW_BLOCK, REG_KEY_HI, 64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_HI, 64'h8000000000000000, 64'h0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_HI, 64'h0, 64'h1, 1'b0, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_HI, 64'h0001020304050607, 64'h0, 1'b0, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_LO, 64'h08090a0b0c0d0e0f, 64'h0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_HI, 64'h0011223344556677, 64'h8899aabbccddeeff,
      1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
    '{ROW_KEY, REG_FIRST_UNUSED, 64'hffffffffffffffff, 64'h0, 1'b0, 64'h0, 64'h0},
    '{ROW_KEY, REG_LAST_UNUSED, 64'hffffffffffffffff, 64'h0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_HI, 64'h0011223344556677, 64'h8899aabbccddeeff,
      1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
    '{ROW_KEY, REG_KEY_HI, 64'h2b7e151628aed2a6, 64'h0, 1'b0, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_LO, 64'habf7158809cf4f3c, 64'h0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_HI, 64'h3243f6a8885a308d, 64'h313198a2e0370734,
      1'b1, 64'h3925841d02dc09fb, 64'hdc118597196a0b32},
    '{ROW_BLOCK, REG_KEY_HI, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_HI, 64'hffffffffffffffff, 64'h0, 1'b0, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_LO, 64'hffffffffffffffff, 64'h0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_HI, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_HI, 64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_HI, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_HI, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_HI, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_LO, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_HI, 64'h0, 64'h0,
      1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e}
  };

  logic clk;
  logic rst;

  aes_cfg_if    cfg_bus ();
  aes_block_if  plain_bus ();
  aes_cipher_if cipher_bus ();

  aes128_block_encrypt #(
    .ROUNDS(ROUNDS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_bus),
    .plain (plain_bus),
    .cipher(cipher_bus)
  );

  logic [7:0]   sub_byte [256];
  half_t        key_hi_now;
  half_t        key_lo_now;
  pin_t         known_cipher_q [$];
  logic [127:0] cipher_due_q [$];
  pin_t         pin_now;
  logic [127:0] due_now;
  int           mismatches;
  int           snd_calm;
  int           cfg_calm;
  int           rcv_calm;
  bit           plain_up;
  bit           cfg_up;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                 input logic [127:0] text);
    logic [7:0] st [16];
    logic [7:0] rk [16];
    logic [7:0] sh [16];
    logic [7:0] w [4];
    logic [7:0] rc;
    logic [127:0] out;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127 - 8 * i -: 8];
      st[i] = text[127 - 8 * i -: 8] ^ rk[i];
    end
    rc = 8'h01;
    for (int rnd = 1; rnd <= ROUNDS; rnd++) begin
      w[0] = sub_byte[rk[13]] ^ rc;
      w[1] = sub_byte[rk[14]];
      w[2] = sub_byte[rk[15]];
      w[3] = sub_byte[rk[12]];
      for (int i = 0; i < 16; i++) begin
        rk[i] = rk[i] ^ ((i < 4) ? w[i] : rk[i - 4]);
      end
      rc = gf_mul(rc, 8'h02);
      // row r of column c takes the byte from column c + r
      for (int i = 0; i < 16; i++) begin
        sh[i] = sub_byte[st[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)]];
      end
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          if (rnd < ROUNDS) begin
            st[4 * c + r] = gf_mul(sh[4 * c + r], 8'h02)
                          ^ gf_mul(sh[4 * c + (r + 1) % 4], 8'h03)
                          ^ sh[4 * c + (r + 2) % 4] ^ sh[4 * c + (r + 3) % 4];
          end else begin
            st[4 * c + r] = sh[4 * c + r];
          end
        end
      end
      for (int i = 0; i < 16; i++) begin
        st[i] = st[i] ^ rk[i];
      end
    end
    for (int i = 0; i < 16; i++) begin
      out[127 - 8 * i -: 8] = st[i];
    end
    return out;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic half_t random_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic half_t corner_word();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return half_t'(1) << $urandom_range(0, 63);
      default: return ~(half_t'(1) << $urandom_range(0, 63));
    endcase
  endfunction

  task automatic report(input string what, input half_t got, input half_t want);
    $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic cfg_write(input cfg_index_t idx, input half_t value);
    int gap;
    gap = pick_gap(cfg_calm);
    if (gap > 0) begin
      if (cfg_up) cfg_bus.valid <= 1'b0;
      cfg_up = 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    cfg_up = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic cfg_release();
    if (cfg_up) cfg_bus.valid <= 1'b0;
    cfg_up = 1'b0;
  endtask

  task automatic send_block(input half_t hi, input half_t lo);
    int gap;
    gap = pick_gap(snd_calm);
    if (gap > 0) begin
      if (plain_up) plain_bus.valid <= 1'b0;
      plain_up = 1'b0;
      repeat (gap) @(posedge clk);
    end
    plain_bus.valid    <= 1'b1;
    plain_bus.block_hi <= hi;
    plain_bus.block_lo <= lo;
    plain_up = 1'b1;
    do @(posedge clk); while (!plain_bus.ready);
  endtask

  task automatic block_release();
    if (plain_up) plain_bus.valid <= 1'b0;
    plain_up = 1'b0;
  endtask

  // hold until every ciphertext transaction owed has come back
  task automatic settle();
    do @(negedge clk); while (cipher_due_q.size() != 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      key_hi_now <= '0;
      key_lo_now <= '0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_KEY_HI: key_hi_now <= cfg_bus.data;
          REG_KEY_LO: key_lo_now <= cfg_bus.data;
          default: ;
        endcase
      end
      if (plain_bus.valid && plain_bus.ready) begin
        pin_now = known_cipher_q.pop_front();
        if (pin_now.fixed) begin
          cipher_due_q.push_back(pin_now.value);
        end else begin
          cipher_due_q.push_back(encrypt_block({key_hi_now, key_lo_now},
                                               {plain_bus.block_hi, plain_bus.block_lo}));
        end
      end
      if (cipher_bus.valid && cipher_bus.ready) begin
        if (cipher_due_q.size() == 0) begin
          report("cipher_hi, nothing pending", cipher_bus.cipher_hi, '0);
        end else begin
          due_now = cipher_due_q.pop_front();
          if (cipher_bus.cipher_hi !== due_now[127:64])
            report("cipher_hi", cipher_bus.cipher_hi, due_now[127:64]);
          if (cipher_bus.cipher_lo !== due_now[63:0])
            report("cipher_lo", cipher_bus.cipher_lo, due_now[63:0]);
        end
      end
    end
  end

  initial begin
    int gap;
    cipher_bus.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      gap = pick_gap(rcv_calm);
      if (gap > 0) begin
        cipher_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cipher_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [7:0]  inv;
    logic [15:0] twice;
    int          sent;
    int          n;
    mismatches = 0;
    snd_calm   = 0;
    cfg_calm   = 0;
    rcv_calm   = 0;
    plain_up   = 1'b0;
    cfg_up     = 1'b0;
    rst                <= 1'b1;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= REG_KEY_HI;
    cfg_bus.data       <= '0;
    plain_bus.valid    <= 1'b0;
    plain_bus.block_hi <= '0;
    plain_bus.block_lo <= '0;

    // multiplicative inverse followed by the affine map
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++) begin
        if (a != 0 && gf_mul(8'(a), 8'(b)) == 8'h01) inv = 8'(b);
      end
      twice = {inv, inv};
      sub_byte[a] = inv ^ twice[14:7] ^ twice[13:6] ^ twice[12:5] ^ twice[11:4] ^ AFFINE_C;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_KEY) begin
        if (plain_up) begin
          block_release();
          settle();
        end
        cfg_write(directed[i].index, directed[i].hi);
      end else begin
        cfg_release();
        known_cipher_q.push_back('{fixed: directed[i].fixed,
                                   value: {directed[i].want_hi, directed[i].want_lo}});
        send_block(directed[i].hi, directed[i].lo);
      end
    end
    block_release();

    sent = 0;
    while (sent < RANDOM_BLOCKS) begin
      settle();
      case ($urandom_range(0, 9))
        0: begin
          cfg_write(REG_KEY_HI, '0);
          cfg_write(REG_KEY_LO, '0);
        end
        1: begin
          cfg_write(REG_KEY_LO, '1);
          cfg_write(REG_KEY_HI, '1);
        end
        2: begin
          cfg_write(REG_KEY_HI, corner_word());
          cfg_write(REG_KEY_LO, corner_word());
        end
        3: cfg_write(REG_KEY_HI, random_word());
        4: cfg_write(REG_KEY_LO, random_word());
        5: begin
          cfg_write(cfg_index_t'($urandom_range(REG_LAST_UNUSED, REG_FIRST_UNUSED)),
                    random_word());
          cfg_write(REG_KEY_LO, random_word());
          cfg_write(REG_KEY_HI, random_word());
        end
        default: begin
          cfg_write(REG_KEY_HI, random_word());
          cfg_write(REG_KEY_LO, random_word());
        end
      endcase
      cfg_release();
      n = $urandom_range(5, 60);
      repeat (n) begin
        known_cipher_q.push_back('{fixed: 1'b0, value: '0});
        if ($urandom_range(0, 9) == 0) begin
          send_block(corner_word(), corner_word());
        end else begin
          send_block(random_word(), random_word());
        end
        sent++;
      end
      block_release();
    end

    do @(negedge clk); while (cipher_due_q.size() != 0);
    repeat (ROUNDS + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
